/* design/execution_time_stats_accumulator_assert.svh */
// Assertion macros for the execution time statistics accumulator
`ifndef EXECUTION_TIME_STATS_ACCUMULATOR_ASSERT_SVH
`define EXECUTION_TIME_STATS_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define ETS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ETS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/ets_pkg.sv */
// Shared types, constants and helpers of the execution time statistics accumulator
package ets_pkg;

  localparam int SLOTS     = 256;
  localparam int KINDS     = 3;
  localparam int FRAC_BITS = 16;
  localparam int SLOT_W    = 8;
  localparam int KIDX_W    = 10;
  localparam int KDEPTH    = SLOTS * KINDS;

  localparam logic [39:0] MAX40 = {40{1'b1}};
  localparam logic [47:0] MAX48 = {48{1'b1}};
  localparam logic [62:0] MAX63 = {63{1'b1}};

  localparam logic [1:0] ORIGIN_GENERIC = 2'd1;
  localparam logic [1:0] ORIGIN_CUSTOM  = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [1:0]        kind;
    logic [31:0]       dur;
    logic [31:0]       rows;
    logic [9:0]        wp;
    logic [9:0]        ws;
    logic [1:0]        origin;
  } item_t;

  typedef struct packed {
    logic [39:0] count;
    logic [47:0] total;
    logic [31:0] min;
    logic [31:0] max;
    logic [47:0] mean;
    logic [62:0] varsum;
  } kind_rec_t;

  typedef struct packed {
    logic [47:0] rows;
    logic [47:0] planned;
    logic [47:0] started;
    logic [39:0] generic;
    logic [39:0] custom;
  } slot_rec_t;

  typedef struct packed {
    kind_rec_t k;
    slot_rec_t s;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } b_stat_t;

  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic [39:0] sat_inc40(logic [39:0] a);
    return (a == MAX40) ? MAX40 : a + 40'd1;
  endfunction

endpackage

/* design/ets_front.sv */
// Front end: accepts requests and drops those with an unused kind
module ets_front (
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [95:0]     s_axis_tdata,
  input  logic [1:0]      s_axis_tuser,
  input  ets_pkg::b_stat_t bstat_i,
  input  ets_pkg::q_stat_t qstat_i,
  output logic            push_o,
  output ets_pkg::item_t  item_o
);
  import ets_pkg::*;

  assign s_axis_tready = !bstat_i.clearing && !qstat_i.full;

  assign item_o.slot   = s_axis_tdata[7:0];
  assign item_o.kind   = s_axis_tuser;
  assign item_o.dur    = s_axis_tdata[39:8];
  assign item_o.rows   = s_axis_tdata[71:40];
  assign item_o.wp     = s_axis_tdata[81:72];
  assign item_o.ws     = s_axis_tdata[91:82];
  assign item_o.origin = s_axis_tdata[93:92];

  assign push_o = s_axis_tvalid && s_axis_tready && (s_axis_tuser < 2'(KINDS));

endmodule

/* design/ets_queue.sv */
// Two-entry request queue between front and back
module ets_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ets_pkg::item_t  item_i,
  input  logic            pop_i,
  output ets_pkg::item_t  head_o,
  output ets_pkg::q_stat_t stat_o
);
  import ets_pkg::*;

  item_t      buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= item_i;
  end

  assign head_o       = buf_q[rp_q];
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

endmodule

/* design/ets_back.sv */
// Back end: statistics stores, clearing pass, divider and multiplier sequencer
module ets_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ets_pkg::item_t   head_i,
  input  ets_pkg::q_stat_t qstat_i,
  output ets_pkg::b_stat_t bstat_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output ets_pkg::result_t res_o
);
  import ets_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_DIV, S_MEAN, S_D2, S_MUL, S_ACC, S_VAR, S_WB
  } state_e;

  state_e            state_q;
  logic [KIDX_W-1:0] clr_q;
  logic [KIDX_W-1:0] kidx_q;
  item_t             item_q;
  kind_rec_t         kmem [KDEPTH];
  slot_rec_t         smem [SLOTS];
  kind_rec_t         krd_q, k_q;
  slot_rec_t         srd_q, s_q;
  logic [47:0]       xq_q, d1_q, d2_q, quo_q;
  logic              ge_q;
  logic [39:0]       n_q, rem_q;
  logic [5:0]        step_q;
  logic [47:0]       pp_q;
  logic [95:0]       acc_q;
  logic [1:0]        mstep_q;
  result_t           res_q;
  logic              valid_q;

  logic              pop, wb_go, clr_en;
  logic [KIDX_W-1:0] hidx;
  logic [47:0]       xq;
  logic [39:0]       n;
  logic [40:0]       r;
  logic              rge;
  logic [23:0]       ma, mb;
  logic [5:0]        shamt;
  logic [79:0]       vsh;
  logic [62:0]       vadd;
  logic [63:0]       vsum;
  kind_rec_t         k_ld;

  assign pop    = (state_q == S_IDLE) && !qstat_i.empty;
  assign wb_go  = (state_q == S_WB) && (!valid_q || m_ready_i);
  assign clr_en = (state_q == S_CLEAR);
  assign hidx   = KIDX_W'({head_i.slot, 1'b0}) + KIDX_W'(head_i.slot) + KIDX_W'(head_i.kind);
  assign xq     = {item_q.dur, {FRAC_BITS{1'b0}}};
  assign n      = sat_inc40(krd_q.count);
  assign r      = {rem_q, quo_q[47]};
  assign rge    = r >= {1'b0, n_q};
  assign ma     = mstep_q[1] ? d1_q[47:24] : d1_q[23:0];
  assign mb     = mstep_q[0] ? d2_q[47:24] : d2_q[23:0];
  assign vsh    = acc_q[95:FRAC_BITS];
  assign vadd   = (|vsh[79:63]) ? MAX63 : vsh[62:0];
  assign vsum   = {1'b0, k_q.varsum} + {1'b0, vadd};

  always_comb begin
    unique case (mstep_q)
      2'd0:    shamt = 6'd0;
      2'd3:    shamt = 6'd48;
      default: shamt = 6'd24;
    endcase
  end

  always_comb begin
    k_ld       = krd_q;
    k_ld.count = n;
    k_ld.total = sat_add48(krd_q.total, 48'(item_q.dur));
    if (n == 40'd1) begin
      k_ld.min  = item_q.dur;
      k_ld.max  = item_q.dur;
      k_ld.mean = xq;
    end else if (krd_q.min == 32'd0 && krd_q.max == 32'd0) begin
      k_ld.min = item_q.dur;
      k_ld.max = item_q.dur;
    end else begin
      if (krd_q.min > item_q.dur) k_ld.min = item_q.dur;
      if (krd_q.max < item_q.dur) k_ld.max = item_q.dur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_en) begin
      kmem[clr_q] <= '0;
      if (clr_q < KIDX_W'(SLOTS)) smem[clr_q[SLOT_W-1:0]] <= '0;
    end else if (wb_go) begin
      kmem[kidx_q]      <= k_q;
      smem[item_q.slot] <= s_q;
    end
    if (pop) begin
      krd_q <= kmem[hidx];
      srd_q <= smem[head_i.slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wb_go) valid_q <= 1'b1;
      else if (m_ready_i) valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + KIDX_W'(1);
          if (clr_q == KIDX_W'(KDEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            item_q  <= head_i;
            kidx_q  <= hidx;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          k_q         <= k_ld;
          s_q.rows    <= sat_add48(srd_q.rows, 48'(item_q.rows));
          s_q.planned <= sat_add48(srd_q.planned, 48'(item_q.wp));
          s_q.started <= sat_add48(srd_q.started, 48'(item_q.ws));
          s_q.generic <= (item_q.origin == ORIGIN_GENERIC) ? sat_inc40(srd_q.generic)
                                                           : srd_q.generic;
          s_q.custom  <= (item_q.origin == ORIGIN_CUSTOM) ? sat_inc40(srd_q.custom)
                                                          : srd_q.custom;
          xq_q <= xq;
          if (n == 40'd1) begin
            state_q  <= S_WB;
          end else begin
            ge_q    <= xq >= krd_q.mean;
            d1_q    <= (xq >= krd_q.mean) ? xq - krd_q.mean : krd_q.mean - xq;
            quo_q   <= (xq >= krd_q.mean) ? xq - krd_q.mean : krd_q.mean - xq;
            n_q     <= n;
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= rge ? 40'(r - {1'b0, n_q}) : r[39:0];
          quo_q  <= {quo_q[46:0], rge};
          step_q <= step_q + 6'd1;
          if (step_q == 6'd47) state_q <= S_MEAN;
        end
        S_MEAN: begin
          k_q.mean <= ge_q ? k_q.mean + quo_q : k_q.mean - quo_q;
          state_q  <= S_D2;
        end
        S_D2: begin
          d2_q    <= ge_q ? xq_q - k_q.mean : k_q.mean - xq_q;
          acc_q   <= '0;
          mstep_q <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          pp_q    <= 48'(ma) * 48'(mb);
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q   <= acc_q + (96'(pp_q) << shamt);
          mstep_q <= mstep_q + 2'd1;
          state_q <= (mstep_q == 2'd3) ? S_VAR : S_MUL;
        end
        S_VAR: begin
          k_q.varsum <= vsum[63] ? MAX63 : vsum[62:0];
          state_q    <= S_WB;
        end
        S_WB: begin
          if (wb_go) begin
            res_q   <= '{k: k_q, s: s_q};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign bstat_o.clearing = clr_en;
  assign bstat_o.pop      = pop;
  assign m_valid_o        = valid_q;
  assign res_o            = res_q;

endmodule

/* design/execution_time_stats_accumulator.sv */
// Top level of the execution time statistics accumulator
// Keeps per slot and kind call counts, time sums, min, max and a Welford running mean and
// squared-deviation sum, plus per slot row and worker totals and generic and custom plan counts;
// every request of a used kind returns the updated figures. After reset a clearing pass over
// all 768 kind entries runs before the first request is taken. A repeat call of a slot and
// kind runs the one-bit-per-cycle 48-step mean divider and the four-pass 24x24 multiplier;
// a first call skips both. Requests with kind 3 are dropped without a result. Two requests
// can queue while the back end works and a result waits in the output register.
`include "execution_time_stats_accumulator_assert.svh"

module execution_time_stats_accumulator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_slot, duration_us, rows, workers_planned, workers_started, plan_origin
  input  logic [95:0]  s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // call_count, total_time_us, min_time_us, max_time_us, mean_time_q16,
  // variance_sum_q16, rows_total, planned_workers_total, started_workers_total,
  // generic_plan_count, custom_plan_count
  output logic [487:0] m_axis_tdata
);
  import ets_pkg::*;

  b_stat_t bstat;
  q_stat_t qstat;
  logic    push;
  item_t   item, head;
  result_t res;

  ets_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .bstat_i       (bstat),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (item)
  );

  ets_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .pop_i  (bstat.pop),
    .head_o (head),
    .stat_o (qstat)
  );

  ets_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .qstat_i   (qstat),
    .bstat_o   (bstat),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res)
  );

  assign m_axis_tdata = {1'b0, res.s.custom, res.s.generic, res.s.started, res.s.planned,
                         res.s.rows, res.k.varsum, res.k.mean, res.k.max, res.k.min,
                         res.k.total, res.k.count};

  `ETS_ASSERT_IMPLY(a_no_accept_clearing, bstat.clearing, !s_axis_tready)
  `ETS_ASSERT_IMPLY(a_no_push_full, push, !qstat.full)
  `ETS_ASSERT_IMPLY(a_pop_has_item, bstat.pop, !qstat.empty)
  `ETS_ASSERT_IMPLY(a_drop_kind, s_axis_tvalid && s_axis_tready && s_axis_tuser == 2'd3, !push)

endmodule

/* test/tb_execution_time_stats_accumulator.sv */
// Testbench of the execution time statistics accumulator: directed and random requests
`timescale 1ns / 100ps

module tb_execution_time_stats_accumulator;
  import ets_pkg::*;

  localparam int KIND_PLAN  = 0;
  localparam int KIND_START = 1;
  localparam int KIND_END   = 2;
  localparam int KIND_BAD   = 3;
  localparam logic [1:0] ORIGIN_OTHER = 2'd0;
  localparam logic [1:0] ORIGIN_NONE  = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD    = 400;

  typedef struct {
    logic [39:0] count;
    logic [47:0] total;
    logic [31:0] tmin;
    logic [31:0] tmax;
    logic [47:0] mean;
    logic [62:0] varsum;
    logic [47:0] rows;
    logic [47:0] planned;
    logic [47:0] started;
    logic [39:0] generic;
    logic [39:0] custom;
  } stats_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [487:0] m_axis_tdata;

  execution_time_stats_accumulator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // shadow statistics table
  logic [39:0] cnt_tab [KDEPTH];
  logic [47:0] tot_tab [KDEPTH];
  logic [31:0] min_tab [KDEPTH];
  logic [31:0] max_tab [KDEPTH];
  logic [47:0] mean_tab[KDEPTH];
  logic [62:0] var_tab [KDEPTH];
  logic [47:0] rows_tab[SLOTS];
  logic [47:0] plan_tab[SLOTS];
  logic [47:0] strt_tab[SLOTS];
  logic [39:0] gen_tab [SLOTS];
  logic [39:0] cus_tab [SLOTS];

  stats_t pending_stats[$];
  int     errors;
  int     sent;
  int     dropped;
  int     checked;
  int     burst_left;
  bit     hold_req;
  int     hold_cnt;
  int     rx_mode;
  int     rx_phase;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic [47:0] add48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic [39:0] inc40(logic [39:0] a);
    return (a == MAX40) ? MAX40 : a + 40'd1;
  endfunction

  function automatic void predict_stats(logic [7:0] slot, logic [1:0] kind, logic [31:0] dur,
                                        logic [31:0] rows, logic [9:0] wp, logic [9:0] ws,
                                        logic [1:0] origin);
    int          idx;
    logic [39:0] n;
    logic [47:0] xq, prev_mean, new_mean;
    logic [63:0] d1, d2, varnew;
    logic [127:0] prod;
    logic [63:0] term;
    stats_t      r;
    idx = int'(slot) * KINDS + int'(kind);
    xq = {dur, 16'd0};
    n = inc40(cnt_tab[idx]);
    cnt_tab[idx] = n;
    tot_tab[idx] = add48(tot_tab[idx], {16'd0, dur});
    if (n == 40'd1) begin
      min_tab[idx] = dur;
      max_tab[idx] = dur;
      mean_tab[idx] = xq;
    end else begin
      prev_mean = mean_tab[idx];
      if (xq >= prev_mean) begin
        d1 = 64'(xq - prev_mean);
        new_mean = prev_mean + 48'(d1 / 64'(n));
        d2 = 64'(xq - new_mean);
      end else begin
        d1 = 64'(prev_mean - xq);
        new_mean = prev_mean - 48'(d1 / 64'(n));
        d2 = 64'(new_mean - xq);
      end
      mean_tab[idx] = new_mean;
      prod = 128'(d1) * 128'(d2);
      prod = prod >> FRAC_BITS;
      term = (prod > 128'(MAX63)) ? 64'(MAX63) : prod[63:0];
      varnew = 64'(var_tab[idx]) + term;
      var_tab[idx] = (varnew > 64'(MAX63)) ? MAX63 : varnew[62:0];
      if (min_tab[idx] == 32'd0 && max_tab[idx] == 32'd0) begin
        min_tab[idx] = dur;
        max_tab[idx] = dur;
      end else begin
        if (min_tab[idx] > dur) min_tab[idx] = dur;
        if (max_tab[idx] < dur) max_tab[idx] = dur;
      end
    end
    rows_tab[slot] = add48(rows_tab[slot], {16'd0, rows});
    plan_tab[slot] = add48(plan_tab[slot], {38'd0, wp});
    strt_tab[slot] = add48(strt_tab[slot], {38'd0, ws});
    if (origin == ORIGIN_GENERIC) gen_tab[slot] = inc40(gen_tab[slot]);
    else if (origin == ORIGIN_CUSTOM) cus_tab[slot] = inc40(cus_tab[slot]);
    r.count = cnt_tab[idx];
    r.total = tot_tab[idx];
    r.tmin = min_tab[idx];
    r.tmax = max_tab[idx];
    r.mean = mean_tab[idx];
    r.varsum = var_tab[idx];
    r.rows = rows_tab[slot];
    r.planned = plan_tab[slot];
    r.started = strt_tab[slot];
    r.generic = gen_tab[slot];
    r.custom = cus_tab[slot];
    pending_stats.push_back(r);
  endfunction

  // drive at the current edge, hold until accepted
  task automatic send_request(logic [7:0] slot, logic [1:0] kind, logic [31:0] dur,
                              logic [31:0] rows, logic [9:0] wp, logic [9:0] ws,
                              logic [1:0] origin);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, origin, ws, wp, rows, dur, slot};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (kind < 2'(KINDS)) predict_stats(slot, kind, dur, rows, wp, ws, origin);
    else dropped++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random(int focus);
    logic [7:0]  slot;
    logic [1:0]  kind;
    logic [31:0] dur;
    int          pick;
    slot = (focus != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) slot = 8'($urandom_range(0, 255));
    kind = ($urandom_range(0, 15) == 0) ? 2'(KIND_BAD) : 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 7);
    case (pick)
      0: dur = 32'd0;
      1: dur = 32'hFFFF_FFFF;
      2: dur = 32'($urandom_range(0, 1000));
      default: dur = $urandom;
    endcase
    send_request(slot, kind, dur, $urandom, 10'($urandom), 10'($urandom),
                 2'($urandom_range(0, 3)));
  endtask

  task automatic test_first_calls();
    send_request(8'd0, 2'(KIND_PLAN), 32'd100, 32'd5, 10'd1, 10'd1, ORIGIN_OTHER);
    send_request(8'd0, 2'(KIND_PLAN), 32'd300, 32'd7, 10'd2, 10'd0, ORIGIN_GENERIC);
    send_request(8'd0, 2'(KIND_START), 32'd50, 32'd0, 10'd0, 10'd0, ORIGIN_CUSTOM);
    send_request(8'd0, 2'(KIND_END), 32'd70, 32'd9, 10'd3, 10'd3, ORIGIN_NONE);
    send_request(8'd255, 2'(KIND_END), 32'd1, 32'd1, 10'd0, 10'd0, ORIGIN_OTHER);
    send_request(8'd255, 2'(KIND_END), 32'd2, 32'd1, 10'd0, 10'd0, ORIGIN_OTHER);
    drain();
  endtask

  task automatic test_zero_restart();
    send_request(8'd10, 2'(KIND_PLAN), 32'd0, 32'd0, 10'd0, 10'd0, ORIGIN_OTHER);
    send_request(8'd10, 2'(KIND_PLAN), 32'd0, 32'd0, 10'd0, 10'd0, ORIGIN_OTHER);
    send_request(8'd10, 2'(KIND_PLAN), 32'd40, 32'd0, 10'd0, 10'd0, ORIGIN_OTHER);
    send_request(8'd10, 2'(KIND_PLAN), 32'd20, 32'd0, 10'd0, 10'd0, ORIGIN_OTHER);
    drain();
  endtask

  task automatic test_dropped_kind();
    send_request(8'd20, 2'(KIND_BAD), 32'd99, 32'd99, 10'd9, 10'd9, ORIGIN_GENERIC);
    send_request(8'd20, 2'(KIND_END), 32'd99, 32'd99, 10'd9, 10'd9, ORIGIN_GENERIC);
    send_request(8'd20, 2'(KIND_BAD), 32'hFFFF_FFFF, 32'd1, 10'd1, 10'd1, ORIGIN_CUSTOM);
    drain();
  endtask

  task automatic test_extremes();
    send_request(8'd30, 2'(KIND_START), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF,
                 ORIGIN_CUSTOM);
    send_request(8'd30, 2'(KIND_START), 32'd0, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF,
                 ORIGIN_GENERIC);
    send_request(8'd30, 2'(KIND_START), 32'hFFFF_FFFF, 32'd0, 10'd0, 10'h3FF, ORIGIN_NONE);
    send_request(8'd30, 2'(KIND_START), 32'd0, 32'hFFFF_FFFF, 10'h3FF, 10'd0, ORIGIN_OTHER);
    send_request(8'd30, 2'(KIND_START), 32'hFFFF_FFFF, 32'h5555_AAAA, 10'h155, 10'h2AA,
                 ORIGIN_CUSTOM);
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (30) send_random(1);
    drain();
  endtask

  task automatic test_random();
    for (int k = 0; k < 900; k++) begin
      send_random((k % 5) != 4);
      if (k == 450) drain();
    end
    drain();
  endtask

  // receiver readiness, with a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= 0;
      rx_mode <= 0;
      rx_phase <= 0;
    end else begin
      rx_phase <= rx_phase + 1;
      if (rx_phase % 97 == 0) rx_mode <= $urandom_range(0, 2);
      if (hold_req && hold_cnt == 0) begin
        hold_req = 1'b0;
        hold_cnt <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= (hold_cnt == 1);
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 0);
          default: m_axis_tready <= ((rx_phase % 7) < 2) ? 1'b0 : ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, m_axis_tdata);
      end else begin
        e = pending_stats.pop_front();
        checked++;
        check_field("call_count", 64'(e.count), 64'(m_axis_tdata[39:0]));
        check_field("total_time_us", 64'(e.total), 64'(m_axis_tdata[87:40]));
        check_field("min_time_us", 64'(e.tmin), 64'(m_axis_tdata[119:88]));
        check_field("max_time_us", 64'(e.tmax), 64'(m_axis_tdata[151:120]));
        check_field("mean_time_q16", 64'(e.mean), 64'(m_axis_tdata[199:152]));
        check_field("variance_sum_q16", 64'(e.varsum), 64'(m_axis_tdata[262:200]));
        check_field("rows_total", 64'(e.rows), 64'(m_axis_tdata[310:263]));
        check_field("planned_workers_total", 64'(e.planned), 64'(m_axis_tdata[358:311]));
        check_field("started_workers_total", 64'(e.started), 64'(m_axis_tdata[406:359]));
        check_field("generic_plan_count", 64'(e.generic), 64'(m_axis_tdata[446:407]));
        check_field("custom_plan_count", 64'(e.custom), 64'(m_axis_tdata[486:447]));
      end
    end
  end

  initial begin
    #20ms;
    $display("execution_time_stats_accumulator regression: fail");
    $finish;
  end

  initial begin
    errors = 0;
    sent = 0;
    dropped = 0;
    checked = 0;
    burst_left = 0;
    hold_req = 1'b0;
    for (int k = 0; k < KDEPTH; k++) begin
      cnt_tab[k] = '0; tot_tab[k] = '0; min_tab[k] = '0;
      max_tab[k] = '0; mean_tab[k] = '0; var_tab[k] = '0;
    end
    for (int k = 0; k < SLOTS; k++) begin
      rows_tab[k] = '0; plan_tab[k] = '0; strt_tab[k] = '0; gen_tab[k] = '0; cus_tab[k] = '0;
    end
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_calls();
    test_zero_restart();
    test_dropped_kind();
    test_extremes();
    test_backpressure();
    test_random();
    if (pending_stats.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_stats.size());
    end
    $display("Covered %0d requests (%0d with an unused kind), %0d results checked,",
             sent, dropped, checked);
    $display("first calls, zero restart, extreme durations and a long output hold-off.");
    if (errors == 0) begin
      $display("execution_time_stats_accumulator regression: pass");
    end else begin
      $display("execution_time_stats_accumulator regression: fail");
    end
    $finish;
  end

endmodule
